/* hw/rtl/dsc_pkg.sv */
`default_nettype none

package dsc_pkg;

  // Window ring length and derived widths
  localparam int unsigned WindowLen = 10;
  localparam int unsigned SumRaw    = WindowLen * 255;
  localparam int unsigned SumBits   = $clog2(SumRaw + 1);
  localparam int unsigned SumW      = (SumBits > 12) ? SumBits : 12;
  localparam logic [11:0] SumMax    = (SumRaw > 4095) ? 12'd4095 : 12'(SumRaw);

  // Calibration bands and steps
  localparam logic [11:0] CoarseBand   = 12'd1000;
  localparam logic [11:0] MidBand      = 12'd200;
  localparam logic [11:0] FineBand     = 12'd100;
  localparam logic [15:0] CoarseStep   = 16'd100;
  localparam logic [15:0] MidStep      = 16'd10;
  localparam logic [15:0] FineDownStep = 16'd2;
  localparam logic [15:0] FineDownMin  = 16'd1;
  localparam logic [2:0]  SettleNeeded = 3'd5;
  localparam logic [2:0]  SettleMax    = 3'd7;
  localparam logic [7:0]  TimerMax     = 8'd255;

  // Register reset values
  localparam logic        MeasureEnableRst = 1'b1;
  localparam logic [11:0] CalTargetRst     = 12'd1200;
  localparam logic [11:0] HighFaultRst     = 12'd2000;
  localparam logic [11:0] LowFaultRst      = 12'd1000;
  localparam logic [7:0]  WindowPeriodRst  = 8'd100;
  localparam logic [7:0]  FaultHoldRst     = 8'd50;
  localparam logic [7:0]  RecalHoldRst     = 8'd50;
  localparam logic [15:0] DacInitialRst    = 16'd3200;

  typedef enum logic [1:0] {
    OpService = 2'd0,
    OpTick    = 2'd1,
    OpPulse   = 2'd2,
    OpUnused  = 2'd3
  } dsc_op_e;

  typedef enum logic [2:0] {
    RegMeasureEnable = 3'd0,
    RegCalTarget     = 3'd1,
    RegHighFault     = 3'd2,
    RegLowFault      = 3'd3,
    RegWindowPeriod  = 3'd4,
    RegFaultHold     = 3'd5,
    RegRecalHold     = 3'd6,
    RegDacInitial    = 3'd7
  } dsc_reg_e;

  typedef enum logic [1:0] {
    PhCal  = 2'b01,
    PhMeas = 2'b10
  } dsc_phase_e;

  typedef struct packed {
    logic        measure_enable;
    logic [11:0] cal_target;
    logic [11:0] high_fault_level;
    logic [11:0] low_fault_level;
    logic [7:0]  window_period;
    logic [7:0]  fault_hold;
    logic [7:0]  recal_hold;
    logic [15:0] dac_initial;
  } dsc_cfg_t;

  // Controller to window chain
  typedef struct packed {
    logic       record;
    logic       clear;
    logic [7:0] count;
  } dsc_win_ctl_t;

  // Controller state after the current item
  typedef struct packed {
    logic        measuring;
    logic [15:0] dac_level;
  } dsc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/dsc_slot_cell.sv */
`default_nettype none

module dsc_slot_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       clear_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] slot_i,
  output logic      [7:0] slot_o
);

  logic [7:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (clear_i) begin
      slot_d = '0;
    end else if (shift_i) begin
      slot_d = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

/* hw/rtl/dsc_ctrl.sv */
`default_nettype none

module dsc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           operation_i,
  input  wire logic [11:0]          cal_sample_i,
  input  wire logic [11:0]          dust_sample_i,
  input  wire dsc_pkg::dsc_cfg_t    cfg_i,
  input  wire logic                 dac_load_i,
  input  wire logic [15:0]          dac_load_value_i,
  output dsc_pkg::dsc_win_ctl_t     win_o,
  output dsc_pkg::dsc_status_t      status_o
);

  dsc_pkg::dsc_phase_e phase_q, phase_d;
  logic [15:0] dac_q, dac_d;
  logic [2:0]  settle_q, settle_d;
  logic [7:0]  cal_timer_q, cal_timer_d;
  logic [7:0]  window_timer_q, window_timer_d;
  logic [7:0]  fault_timer_q, fault_timer_d;
  logic [7:0]  recal_timer_q, recal_timer_d;
  logic [7:0]  pulse_q, pulse_d;
  logic        record, clear;

  logic [11:0] diff_up, diff_down;
  logic        coarse_up;
  logic [16:0] dac_up;
  logic [15:0] dac_s1, dac_s2, dac_s3;
  logic [2:0]  settle_inc;

  // Datapath for a calibrate step
  always_comb begin
    diff_up   = cal_sample_i - cfg_i.cal_target;
    diff_down = cfg_i.cal_target - cal_sample_i;
    coarse_up = diff_up > dsc_pkg::CoarseBand;
    dac_up    = {1'b0, dac_q} + {1'b0, (coarse_up ? dsc_pkg::CoarseStep : dsc_pkg::MidStep)};
    // cascade of decrease tests, each on the previous result
    dac_s1 = (diff_down > dsc_pkg::CoarseBand && dac_q > dsc_pkg::CoarseStep) ?
             dac_q - dsc_pkg::CoarseStep : dac_q;
    dac_s2 = (diff_down > dsc_pkg::MidBand && dac_s1 > dsc_pkg::MidStep) ?
             dac_s1 - dsc_pkg::MidStep : dac_s1;
    dac_s3 = (diff_down > dsc_pkg::FineBand && dac_s2 > dsc_pkg::FineDownMin) ?
             dac_s2 - dsc_pkg::FineDownStep : dac_s2;
    settle_inc = (settle_q < dsc_pkg::SettleMax) ? settle_q + 3'd1 : settle_q;
  end

  always_comb begin
    phase_d        = phase_q;
    dac_d          = dac_q;
    settle_d       = settle_q;
    cal_timer_d    = cal_timer_q;
    window_timer_d = window_timer_q;
    fault_timer_d  = fault_timer_q;
    recal_timer_d  = recal_timer_q;
    pulse_d        = pulse_q;
    record         = 1'b0;
    clear          = 1'b0;

    if (accept_i) begin
      case (dsc_pkg::dsc_op_e'(operation_i))
        dsc_pkg::OpTick: begin
          if (cal_timer_q != dsc_pkg::TimerMax) cal_timer_d = cal_timer_q + 8'd1;
          if (window_timer_q != dsc_pkg::TimerMax) window_timer_d = window_timer_q + 8'd1;
          if (fault_timer_q != dsc_pkg::TimerMax) fault_timer_d = fault_timer_q + 8'd1;
          if (recal_timer_q != dsc_pkg::TimerMax) recal_timer_d = recal_timer_q + 8'd1;
        end
        dsc_pkg::OpPulse: begin
          if (pulse_q != dsc_pkg::TimerMax) pulse_d = pulse_q + 8'd1;
        end
        dsc_pkg::OpService: begin
          case (phase_q)
            dsc_pkg::PhCal: begin
              if (cal_timer_q != 8'd0) begin
                cal_timer_d = '0;
                if (cal_sample_i > cfg_i.cal_target) begin
                  if (!coarse_up || dac_q < cfg_i.dac_initial) begin
                    dac_d = dac_up[16] ? 16'hFFFF : dac_up[15:0];
                  end
                  settle_d = '0;
                end else begin
                  dac_d = dac_s3;
                  if (diff_down > dsc_pkg::FineBand) begin
                    settle_d = '0;
                  end else begin
                    settle_d = settle_inc;
                    if (settle_inc >= dsc_pkg::SettleNeeded) begin
                      phase_d       = dsc_pkg::PhMeas;
                      clear         = 1'b1;
                      fault_timer_d = '0;
                      recal_timer_d = '0;
                    end
                  end
                end
              end
              // clamp the fault timer on every calibrate step
              if (fault_timer_d >= cfg_i.fault_hold) fault_timer_d = cfg_i.fault_hold;
            end
            dsc_pkg::PhMeas: begin
              if (dust_sample_i > cfg_i.high_fault_level) begin
                if (fault_timer_q >= cfg_i.fault_hold) begin
                  fault_timer_d = cfg_i.fault_hold;
                  phase_d       = dsc_pkg::PhCal;
                end
              end else if (dust_sample_i > cfg_i.cal_target) begin
                if (recal_timer_q >= cfg_i.recal_hold) phase_d = dsc_pkg::PhCal;
                fault_timer_d = '0;
              end else if (dust_sample_i < cfg_i.low_fault_level) begin
                if (fault_timer_q >= cfg_i.fault_hold) begin
                  fault_timer_d = '0;
                  phase_d       = dsc_pkg::PhCal;
                end
              end else begin
                fault_timer_d = '0;
              end
              // window check runs on the same step even if the phase drops
              if (window_timer_q >= cfg_i.window_period) begin
                window_timer_d = '0;
                if (cfg_i.measure_enable) begin
                  record  = 1'b1;
                  pulse_d = '0;
                end
              end
            end
            default: begin
              phase_d = dsc_pkg::PhCal;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (dac_load_i) dac_d = dac_load_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= dsc_pkg::PhCal;
      dac_q          <= dsc_pkg::DacInitialRst;
      settle_q       <= '0;
      cal_timer_q    <= '0;
      window_timer_q <= '0;
      fault_timer_q  <= '0;
      recal_timer_q  <= '0;
      pulse_q        <= '0;
    end else begin
      phase_q        <= phase_d;
      dac_q          <= dac_d;
      settle_q       <= settle_d;
      cal_timer_q    <= cal_timer_d;
      window_timer_q <= window_timer_d;
      fault_timer_q  <= fault_timer_d;
      recal_timer_q  <= recal_timer_d;
      pulse_q        <= pulse_d;
    end
  end

  assign win_o.record        = record;
  assign win_o.clear         = clear;
  assign win_o.count         = pulse_q;
  assign status_o.measuring  = (phase_d == dsc_pkg::PhMeas);
  assign status_o.dac_level  = dac_d;

endmodule

`default_nettype wire

/* hw/rtl/dust_sensor_calibrate_and_count.sv */
// Dust sensor controller: calibrate phase, then measure phase.
//
// Input channel (in_valid_i / in_stall_o): one word per item, operation_i
// picks a service step (uses cal_sample_i or dust_sample_i), a timer tick,
// or a dust pulse. Operation code 3 changes nothing but still reports.
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word, in order: dac_drive_o, window_sum_o, measuring_o, all taken
// after the item's update.
// out_valid_o rises in the cycle after acceptance. Throughput is one word per
// cycle while out_stall_i is low: all state updates finish in the accepting
// cycle, and the window is a row of slot cells that shift on each record
// while a running sum adds the new count and drops the last cell's count.
// When the receiver stalls, the result is held in the output register and
// in_stall_o rises only while that register is full and stalled.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while idle. Writing dac_initial also
// loads the drive level.
// Reset: registers go to their defaults, phase is calibrate, drive equals
// dac_initial, timers, counters, slot cells and the sum are cleared.
`default_nettype none

module dust_sensor_calibrate_and_count (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [11:0] cal_sample_i,
  input  wire logic [11:0] dust_sample_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      dac_drive_o,
  output logic [11:0]      window_sum_o,
  output logic             measuring_o,
  // configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  dsc_pkg::dsc_cfg_t     cfg_q, cfg_d;
  dsc_pkg::dsc_win_ctl_t win;
  dsc_pkg::dsc_status_t  status;
  logic                  accept;
  logic                  cfg_wr;
  logic                  dac_load;

  logic [7:0]              slot_out [dsc_pkg::WindowLen];
  logic [dsc_pkg::SumW-1:0] sum_q, sum_d;
  logic [11:0]             sum_sat;

  logic        out_valid_q, out_valid_d;
  logic [15:0] dac_out_q;
  logic [11:0] sum_out_q;
  logic        meas_out_q;

  // Accept a word whenever the output register is free or draining
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  // Configuration registers
  always_comb begin
    cfg_d    = cfg_q;
    dac_load = 1'b0;
    if (cfg_wr) begin
      case (dsc_pkg::dsc_reg_e'(cfg_index_i))
        dsc_pkg::RegMeasureEnable: cfg_d.measure_enable   = cfg_data_i[0];
        dsc_pkg::RegCalTarget:     cfg_d.cal_target       = cfg_data_i[11:0];
        dsc_pkg::RegHighFault:     cfg_d.high_fault_level = cfg_data_i[11:0];
        dsc_pkg::RegLowFault:      cfg_d.low_fault_level  = cfg_data_i[11:0];
        dsc_pkg::RegWindowPeriod:  cfg_d.window_period    = cfg_data_i[7:0];
        dsc_pkg::RegFaultHold:     cfg_d.fault_hold       = cfg_data_i[7:0];
        dsc_pkg::RegRecalHold:     cfg_d.recal_hold       = cfg_data_i[7:0];
        dsc_pkg::RegDacInitial: begin
          cfg_d.dac_initial = cfg_data_i;
          dac_load          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.measure_enable   <= dsc_pkg::MeasureEnableRst;
      cfg_q.cal_target       <= dsc_pkg::CalTargetRst;
      cfg_q.high_fault_level <= dsc_pkg::HighFaultRst;
      cfg_q.low_fault_level  <= dsc_pkg::LowFaultRst;
      cfg_q.window_period    <= dsc_pkg::WindowPeriodRst;
      cfg_q.fault_hold       <= dsc_pkg::FaultHoldRst;
      cfg_q.recal_hold       <= dsc_pkg::RecalHoldRst;
      cfg_q.dac_initial      <= dsc_pkg::DacInitialRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Phase control, DAC loop, timers and pulse counter
  dsc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .operation_i      (operation_i),
    .cal_sample_i     (cal_sample_i),
    .dust_sample_i    (dust_sample_i),
    .cfg_i            (cfg_q),
    .dac_load_i       (dac_load),
    .dac_load_value_i (cfg_data_i),
    .win_o            (win),
    .status_o         (status)
  );

  // Window: a row of slot cells; each record shifts the newest count in.
  // The sum does not depend on slot order, so a shift row stands for the ring.
  for (genvar k = 0; k < dsc_pkg::WindowLen; k++) begin : g_slot
    if (k == 0) begin : g_head
      dsc_slot_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clear_i (win.clear),
        .shift_i (win.record),
        .slot_i  (win.count),
        .slot_o  (slot_out[k])
      );
    end else begin : g_body
      dsc_slot_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clear_i (win.clear),
        .shift_i (win.record),
        .slot_i  (slot_out[k-1]),
        .slot_o  (slot_out[k])
      );
    end
  end

  // Running sum: add the incoming count, drop the one leaving the row
  always_comb begin
    sum_d = sum_q;
    if (win.clear) begin
      sum_d = '0;
    end else if (win.record) begin
      sum_d = sum_q + dsc_pkg::SumW'(win.count)
                    - dsc_pkg::SumW'(slot_out[dsc_pkg::WindowLen-1]);
    end
    sum_sat = (sum_d > dsc_pkg::SumW'(12'hFFF)) ? 12'hFFF : sum_d[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Output register: load on accept, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dac_out_q  <= status.dac_level;
      sum_out_q  <= sum_sat;
      meas_out_q <= status.measuring;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dac_drive_o  = dac_out_q;
  assign window_sum_o = sum_out_q;
  assign measuring_o  = meas_out_q;

endmodule

`default_nettype wire

/* hw/rtl/dsc_checker.sv */
`default_nettype none

module dsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] dac_drive_o,
  input wire logic [11:0] window_sum_o,
  input wire logic        measuring_o
);

  // Input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Every accepted word shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word gave no result");

  // Window sum stays within what the slots can hold
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_sum_o <= dsc_pkg::SumMax))
    else $error("window sum out of range");

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(dac_drive_o) && $stable(window_sum_o) && $stable(measuring_o)))
    else $error("stalled result changed");

endmodule

bind dust_sensor_calibrate_and_count dsc_checker u_dsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .dac_drive_o  (dac_drive_o),
  .window_sum_o (window_sum_o),
  .measuring_o  (measuring_o)
);

`default_nettype wire
